FILE: rtl/bclu_pkg.sv
`default_nettype none

package bclu_pkg;

  localparam int unsigned LANE_W   = 64;
  localparam int unsigned VISIT_W  = 32;
  localparam int unsigned REFILL_W = 8;
  localparam int unsigned KSUM_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COL_W    = 9;
  localparam int unsigned PIX_W    = 18;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              chunk_end;
  } byte_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel_index;
    logic [LANE_W-1:0]   lane_value;
    logic                lane_refilled;
    logic [REFILL_W-1:0] refill_total;
    logic [KSUM_W-1:0]   k_sum_low;
    logic [VISIT_W-1:0]  visit_total;
    logic                chunk_done;
  } result_item_t;

  typedef struct packed {
    logic                touched;
    logic [LANE_W-1:0]   lane;
    logic [VISIT_W-1:0]  visit;
    logic [REFILL_W-1:0] refill;
    logic [KSUM_W-1:0]   ksum;
  } pixel_word_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic read;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/bclu_ctrl.sv
`default_nettype none

module bclu_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            byte_valid,
  output logic                 byte_stall,
  output logic                 result_valid,
  input  wire logic            result_stall,
  input  wire bclu_pkg::status_t status,
  output bclu_pkg::cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  state_t state;

  always_comb begin
    cmd        = '0;
    cmd.clear  = (state == ST_CLEAR);
    cmd.load   = (state == ST_IDLE) && byte_valid;
    cmd.read   = (state == ST_READ);
    cmd.update = (state == ST_UPDATE) && (!result_valid || !result_stall);
    byte_stall = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (byte_valid) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (cmd.update) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
      if (cmd.update) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bclu_datapath.sv
`default_nettype none

module bclu_datapath #(
  parameter int unsigned CANVAS_ROWS = 512,
  parameter int unsigned STEP_BITS   = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        limit_we,
  input  wire logic [bclu_pkg::LANE_W-1:0] limit_data,
  input  wire bclu_pkg::byte_item_t        byte_item,
  input  wire bclu_pkg::cmd_t              cmd,
  output bclu_pkg::status_t                status,
  output bclu_pkg::result_item_t           result_item
);

  localparam int unsigned DEPTH  = CANVAS_ROWS * (2 ** bclu_pkg::COL_W);
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned ROW_W  = ADDR_W - bclu_pkg::COL_W;

  bclu_pkg::pixel_word_t mem [DEPTH];

  logic [bclu_pkg::LANE_W-1:0] lane_limit;
  logic [STEP_BITS-1:0]        step;
  logic [STEP_BITS-1:0]        step_next;
  logic [ROW_W-1:0]            row;
  logic [ROW_W-1:0]            row_next;
  logic [bclu_pkg::COL_W-1:0]  col;
  logic                        chunk;
  logic [ADDR_W-1:0]           clr_cnt;
  logic [STEP_BITS:0]          k_sum_w;
  logic [STEP_BITS-1:0]        k;
  bclu_pkg::pixel_word_t       rd_word;
  bclu_pkg::pixel_word_t       wr_word;
  bclu_pkg::pixel_word_t       mem_wdata;
  logic [ADDR_W-1:0]           pix_addr;
  logic [ADDR_W-1:0]           mem_waddr;
  logic                        mem_we;
  logic [bclu_pkg::LANE_W-1:0] lane_old;
  logic [bclu_pkg::LANE_W-1:0] k_wide;
  logic                        refilled;

  assign pix_addr          = {row, col};
  assign status.clear_last = (clr_cnt == ADDR_W'(DEPTH - 1));

  always_comb begin
    step_next = step + STEP_BITS'(1);
    if (step_next == '0) begin
      row_next = '0;
    end else if (row == ROW_W'(CANVAS_ROWS - 1)) begin
      row_next = '0;
    end else begin
      row_next = row + ROW_W'(1);
    end
  end

  always_comb begin
    k_sum_w = {1'b0, step} + (STEP_BITS + 1)'(1);
    k_wide  = bclu_pkg::LANE_W'(k);
    lane_old = rd_word.touched ? rd_word.lane : lane_limit;
    refilled = (lane_old < k_wide);
    wr_word.touched = 1'b1;
    wr_word.lane    = (refilled ? lane_limit : lane_old) - k_wide;
    wr_word.visit   = rd_word.visit + bclu_pkg::VISIT_W'(1);
    wr_word.refill  = rd_word.refill + bclu_pkg::REFILL_W'(refilled);
    wr_word.ksum    = rd_word.ksum + k[bclu_pkg::KSUM_W-1:0];
    mem_we    = cmd.clear || cmd.update;
    mem_waddr = cmd.clear ? clr_cnt : pix_addr;
    mem_wdata = cmd.clear ? '0 : wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_limit <= '1;
      step       <= '0;
      row        <= '0;
      clr_cnt    <= '0;
    end else begin
      if (limit_we) begin
        lane_limit <= limit_data;
      end
      if (cmd.load) begin
        step <= step_next;
        row  <= row_next;
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col   <= {~step_next[0], byte_item.data_byte};
      chunk <= byte_item.chunk_end;
    end
    if (cmd.read) begin
      k <= k_sum_w[STEP_BITS:1];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rd_word <= mem[pix_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result_item.pixel_index   <= bclu_pkg::PIX_W'(pix_addr);
      result_item.lane_value    <= wr_word.lane;
      result_item.lane_refilled <= refilled;
      result_item.refill_total  <= wr_word.refill;
      result_item.k_sum_low     <= wr_word.ksum;
      result_item.visit_total   <= wr_word.visit;
      result_item.chunk_done    <= chunk;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/byte_canvas_lane_update.sv
// Each accepted byte advances the step count and updates one pixel of a canvas of CANVAS_ROWS
// rows by 512 columns, held in a single-port memory of CANVAS_ROWS * 512 words; one result item
// reports the pixel's new lane value and counters. After reset the block runs a clearing pass that
// zeroes all CANVAS_ROWS * 512 words with byte_stall high; lane limit writes are taken at any time.
// An item then passes accept, memory read, and update with write back. No new byte is accepted until
// its update is done, which the read-modify-write of the pixel memory requires, and the update waits
// while a held result stalls. A finished result waits in the output register while the next byte is
// accepted. Pixels never touched since reset read as the lane limit current at their first visit.
`default_nettype none

module byte_canvas_lane_update #(
  parameter int unsigned CANVAS_ROWS = 512,
  parameter int unsigned STEP_BITS   = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        limit_we,
  input  wire logic [bclu_pkg::LANE_W-1:0] limit_data,
  input  wire logic                        byte_valid,
  output logic                             byte_stall,
  input  wire bclu_pkg::byte_item_t        byte_item,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output bclu_pkg::result_item_t           result_item
);

  bclu_pkg::cmd_t    cmd;
  bclu_pkg::status_t status;

  bclu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  bclu_datapath #(
    .CANVAS_ROWS (CANVAS_ROWS),
    .STEP_BITS   (STEP_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .limit_we    (limit_we),
    .limit_data  (limit_data),
    .byte_item   (byte_item),
    .cmd         (cmd),
    .status      (status),
    .result_item (result_item)
  );

endmodule

`default_nettype wire
